// ===== sv/vtb_pkg.sv =====
// vtb_pkg: shared types, sizes and the control store of the virtual timer bank
// holds the operation codes, step enum and the microprogram read by virtual_timer_bank
// depends on nothing
`default_nettype none

package vtb_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int ID_W       = 4;
  localparam int CNT_W      = 32;
  localparam int OP_W       = 3;
  // allocate only hands out ids that fit the 4-bit grant field
  localparam int ID_LIMIT   = 1 << ID_W;
  localparam int ALLOC_LIM  = (NUM_TIMERS < ID_LIMIT) ? NUM_TIMERS : ID_LIMIT;

  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd1;
  localparam logic [OP_W-1:0] OP_SET     = 3'd2;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_A,
    S_TICK_B,
    S_TICK_C,
    S_TICK_D,
    S_ALLOC_A,
    S_ALLOC_B,
    S_ALLOC_C,
    S_SET_A,
    S_REL_A,
    S_READ_A,
    S_READ_B,
    S_NOP_A
  } step_t;

  typedef enum logic {
    A_PTR,
    A_ID
  } addr_sel_t;

  typedef enum logic [1:0] {
    P_HOLD,
    P_LOAD0,
    P_LOAD1,
    P_INC
  } ptr_op_t;

  typedef enum logic [2:0] {
    W_NONE,
    W_DEC,
    W_ALLOC,
    W_SET,
    W_ZERO
  } wr_op_t;

  typedef enum logic [1:0] {
    R_NONE,
    R_ZERO,
    R_ALLOC,
    R_READ
  } res_op_t;

  typedef enum logic [1:0] {
    J_SEQ,
    J_GOTO,
    J_UNTIL_TICK,
    J_UNTIL_ALLOC
  } jmp_t;

  typedef struct packed {
    logic      rd_en;
    addr_sel_t amode;
    ptr_op_t   ptr_op;
    wr_op_t    wr_op;
    res_op_t   res_op;
    jmp_t      jmp;
    step_t     tgt;
  } uword_t;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{rd_en: 1'b0, amode: A_PTR, ptr_op: P_HOLD, wr_op: W_NONE,
          res_op: R_NONE, jmp: J_GOTO, tgt: S_IDLE};
    unique case (s)
      S_IDLE: ;
      S_TICK_A: begin
        w.ptr_op = P_LOAD0;
        w.jmp    = J_SEQ;
      end
      S_TICK_B: begin
        w.rd_en  = 1'b1;
        w.ptr_op = P_INC;
        w.jmp    = J_SEQ;
      end
      // read the next entry while writing back the one read last cycle
      S_TICK_C: begin
        w.rd_en  = 1'b1;
        w.ptr_op = P_INC;
        w.wr_op  = W_DEC;
        w.jmp    = J_UNTIL_TICK;
        w.tgt    = S_TICK_D;
      end
      S_TICK_D: begin
        w.res_op = R_ZERO;
      end
      S_ALLOC_A: begin
        w.ptr_op = P_LOAD1;
        w.jmp    = J_SEQ;
      end
      S_ALLOC_B: begin
        w.rd_en  = 1'b1;
        w.ptr_op = P_INC;
        w.jmp    = J_SEQ;
      end
      S_ALLOC_C: begin
        w.rd_en  = 1'b1;
        w.ptr_op = P_INC;
        w.wr_op  = W_ALLOC;
        w.res_op = R_ALLOC;
        w.jmp    = J_UNTIL_ALLOC;
      end
      S_SET_A: begin
        w.wr_op  = W_SET;
        w.res_op = R_ZERO;
      end
      S_REL_A: begin
        w.wr_op  = W_ZERO;
        w.res_op = R_ZERO;
      end
      S_READ_A: begin
        w.rd_en = 1'b1;
        w.amode = A_ID;
        w.jmp   = J_SEQ;
      end
      S_READ_B: begin
        w.res_op = R_READ;
      end
      S_NOP_A: begin
        w.res_op = R_ZERO;
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic step_t op_entry(input logic [OP_W-1:0] op);
    step_t s;
    unique case (op)
      OP_TICK:    s = S_TICK_A;
      OP_ALLOC:   s = S_ALLOC_A;
      OP_SET:     s = S_SET_A;
      OP_RELEASE: s = S_REL_A;
      OP_READ:    s = S_READ_A;
      default:    s = S_NOP_A;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/virtual_timer_bank.sv =====
// virtual_timer_bank: bank of down-counting timers run by a small microprogram
// uses vtb_pkg for sizes, operation codes and the control store
//
// usage: present op, timer_id and period with start high while busy is low;
// the word is taken at that clock edge and busy rises in the next cycle.
// every operation gives exactly one result: done is high for one cycle with
// granted_id, grant_ok, count_value and fired valid in that cycle. results
// cannot be held off; the block never waits on the receiver.
// each operation runs as a sequence of steps (busy drops as done rises):
//   tick     every entry in turn, one entry per cycle through the count memory
//   allocate scans up from id 1, stopping at the granted id or at ALLOC_LIM - 1
//   set and release write the entry by id, unknown ops do nothing; read reads it
// a new word can be taken in the cycle done is high. the count memory has one
// read port and one write port, both driven by the step counter.
// reset (rst, synchronous) clears the entry valid bits so every timer reads
// as free at once, returns the step counter to idle and drops done.
`default_nettype none

module virtual_timer_bank
  import vtb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [OP_W-1:0]   op,
  input  wire logic [ID_W-1:0]   timer_id,
  input  wire logic [CNT_W-1:0]  period,
  output logic                   busy,
  output logic                   done,
  output logic [ID_W-1:0]        granted_id,
  output logic                   grant_ok,
  output logic [CNT_W-1:0]       count_value,
  output logic                   fired
);

  step_t             upc;
  step_t             upc_next;
  uword_t            uw;

  logic [ID_W-1:0]   id_q;
  logic [CNT_W-1:0]  period_q;
  logic [IDX_W-1:0]  ptr;
  logic [IDX_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  rd_data;

  logic [CNT_W-1:0]  mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] vld;

  logic [IDX_W-1:0]  raddr;
  logic              raddr_ok;
  logic              id_valid;
  logic              tick_last;
  logic              alloc_hit;
  logic              alloc_end;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [CNT_W-1:0]  wdata;
  logic [CNT_W-1:0]  set_val;

  assign uw        = ucode(upc);
  assign busy      = (upc != S_IDLE);
  assign id_valid  = (32'(id_q) < NUM_TIMERS);
  assign raddr     = (uw.amode == A_ID) ? IDX_W'(id_q) : ptr;
  assign raddr_ok  = (32'(raddr) < NUM_TIMERS);
  assign tick_last = (rd_ptr == IDX_W'(NUM_TIMERS - 1));
  assign alloc_hit = (rd_data == '0);
  assign alloc_end = alloc_hit || (rd_ptr == IDX_W'(ALLOC_LIM - 1));
  // period + 1, saturating so a set never frees the entry
  assign set_val   = (period_q == '1) ? period_q : period_q + CNT_W'(1);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  always_comb begin
    upc_next = upc;
    if (upc == S_IDLE) begin
      if (start) begin
        upc_next = op_entry(op);
      end
    end else begin
      unique case (uw.jmp)
        J_SEQ:         upc_next = step_t'(upc + 4'd1);
        J_GOTO:        upc_next = uw.tgt;
        J_UNTIL_TICK:  upc_next = tick_last ? uw.tgt : upc;
        J_UNTIL_ALLOC: upc_next = alloc_end ? uw.tgt : upc;
        default:       upc_next = S_IDLE;
      endcase
    end
  end

  // captured command word
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      id_q     <= timer_id;
      period_q <= period;
    end
  end

  // scan pointer
  always_ff @(posedge clk) begin
    case (uw.ptr_op)
      P_LOAD0: ptr <= '0;
      P_LOAD1: ptr <= IDX_W'(1);
      P_INC:   ptr <= ptr + IDX_W'(1);
      default: ptr <= ptr;
    endcase
  end

  // write port decode
  always_comb begin
    we    = 1'b0;
    waddr = rd_ptr;
    wdata = '0;
    case (uw.wr_op)
      W_DEC: begin
        we    = (rd_data > CNT_W'(1));
        wdata = rd_data - CNT_W'(1);
      end
      W_ALLOC: begin
        we    = alloc_hit;
        wdata = CNT_W'(1);
      end
      W_SET: begin
        we    = id_valid;
        waddr = IDX_W'(id_q);
        wdata = set_val;
      end
      W_ZERO: begin
        we    = id_valid;
        waddr = IDX_W'(id_q);
      end
      default: ;
    endcase
  end

  // count memory, entries never written read as free
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (uw.rd_en) begin
      rd_ptr  <= raddr;
      rd_data <= (raddr_ok && vld[raddr]) ? mem[raddr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (uw.res_op)
        R_ZERO: done <= 1'b1;
        R_ALLOC: done <= alloc_end;
        R_READ: done <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (uw.res_op)
      R_ZERO: begin
        granted_id  <= '0;
        grant_ok    <= 1'b0;
        count_value <= '0;
        fired       <= 1'b0;
      end
      R_ALLOC: begin
        granted_id  <= alloc_hit ? ID_W'(rd_ptr) : '0;
        grant_ok    <= alloc_hit;
        count_value <= '0;
        fired       <= 1'b0;
      end
      R_READ: begin
        granted_id  <= '0;
        grant_ok    <= 1'b0;
        count_value <= id_valid ? rd_data : '0;
        fired       <= id_valid && (rd_data == CNT_W'(1));
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/virtual_timer_bank_checker.sv =====
// virtual_timer_bank_checker: watches the command and result channels of the timer bank
// keeps its own copy of the sixteen counts, predicts every result and compares
// depends on vtb_pkg for sizes and operation codes
module virtual_timer_bank_checker
  import vtb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [OP_W-1:0]  op,
  input  logic [ID_W-1:0]  timer_id,
  input  logic [CNT_W-1:0] period,
  input  logic             done,
  input  logic [ID_W-1:0]  granted_id,
  input  logic             grant_ok,
  input  logic [CNT_W-1:0] count_value,
  input  logic             fired,
  output int               errors,
  output int               pending,
  output int               fired_reads,
  output int               full_allocs
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ID_W-1:0]  granted_id;
    logic             grant_ok;
    logic [CNT_W-1:0] count_value;
    logic             fired;
  } outcome_t;

  logic [CNT_W-1:0] counts [NUM_TIMERS];
  outcome_t         expected_outcomes [$];
  int               n_fail = 0;
  int               n_fired = 0;
  int               n_full = 0;

  // applies one word to the count copy and returns what the bank should answer
  function automatic outcome_t advance_bank(input logic [OP_W-1:0] o,
                                            input logic [ID_W-1:0] id,
                                            input logic [CNT_W-1:0] per);
    outcome_t r;
    logic     found;
    r = '0;
    found = 1'b0;
    case (o)
      OP_TICK: begin
        for (int k = 0; k < NUM_TIMERS; k++)
          if (counts[k] > 1) counts[k] = counts[k] - 1'b1;
      end
      OP_ALLOC: begin
        // id 0 is reserved and never handed out
        for (int k = 1; k < ALLOC_LIM; k++) begin
          if (!found && counts[k] == '0) begin
            counts[k]    = 1;
            r.granted_id = ID_W'(k);
            r.grant_ok   = 1'b1;
            found        = 1'b1;
          end
        end
      end
      OP_SET: begin
        if (int'(id) < NUM_TIMERS) counts[id] = (per == '1) ? '1 : per + 1'b1;
      end
      OP_RELEASE: begin
        if (int'(id) < NUM_TIMERS) counts[id] = '0;
      end
      OP_READ: begin
        if (int'(id) < NUM_TIMERS) begin
          r.count_value = counts[id];
          r.fired       = (counts[id] == 1);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      for (int k = 0; k < NUM_TIMERS; k++) counts[k] = '0;
      expected_outcomes.delete();
    end else begin
      // the result of an older word is retired before a word taken at the same edge
      if (done) begin
        got.granted_id  = granted_id;
        got.grant_ok    = grant_ok;
        got.count_value = count_value;
        got.fired       = fired;
        if (expected_outcomes.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: result with none expected: id %0d ok %0b count %0h fired %0b",
                     $realtime, got.granted_id, got.grant_ok, got.count_value, got.fired);
        end else begin
          want = expected_outcomes.pop_front();
          if (got.granted_id !== want.granted_id || got.grant_ok !== want.grant_ok ||
              got.count_value !== want.count_value || got.fired !== want.fired) begin
            n_fail++;
            if (n_fail <= 10)
              $display("%0t: mismatch want id %0d ok %0b count %0h fired %0b,",
                       $realtime, want.granted_id, want.grant_ok, want.count_value,
                       want.fired, " got id %0d ok %0b count %0h fired %0b",
                       got.granted_id, got.grant_ok, got.count_value, got.fired);
          end
        end
      end
      if (start && !busy) begin
        want = advance_bank(op, timer_id, period);
        if (op == OP_READ && want.fired) n_fired++;
        if (op == OP_ALLOC && !want.grant_ok) n_full++;
        expected_outcomes.push_back(want);
      end
    end
    errors      <= n_fail;
    pending     <= expected_outcomes.size();
    fired_reads <= n_fired;
    full_allocs <= n_full;
  end

endmodule

// ===== tb/virtual_timer_bank_tb.sv =====
// virtual_timer_bank_tb: drives words into the timer bank and gives the verdict
// needs vtb_pkg, virtual_timer_bank and virtual_timer_bank_checker
module virtual_timer_bank_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vtb_pkg::*;

  localparam int RANDOM_WORDS = 1250;
  localparam int IDLE_LIMIT   = 2000;

  logic             clk;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [OP_W-1:0]  op = '0;
  logic [ID_W-1:0]  timer_id = '0;
  logic [CNT_W-1:0] period = '0;
  logic             busy;
  logic             done;
  logic [ID_W-1:0]  granted_id;
  logic             grant_ok;
  logic [CNT_W-1:0] count_value;
  logic             fired;

  int errors;
  int pending;
  int fired_reads;
  int full_allocs;

  int n_issued = 0;
  int op_seen [8];
  bit gaps_on = 1'b1;
  int idle_cycles = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  virtual_timer_bank u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op         (op),
    .timer_id   (timer_id),
    .period     (period),
    .busy       (busy),
    .done       (done),
    .granted_id (granted_id),
    .grant_ok   (grant_ok),
    .count_value(count_value),
    .fired      (fired)
  );

  virtual_timer_bank_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .timer_id   (timer_id),
    .period     (period),
    .done       (done),
    .granted_id (granted_id),
    .grant_ok   (grant_ok),
    .count_value(count_value),
    .fired      (fired),
    .errors     (errors),
    .pending    (pending),
    .fired_reads(fired_reads),
    .full_allocs(full_allocs)
  );

  // presents a word and holds it until the bank takes it
  task automatic issue(input logic [OP_W-1:0] o, input logic [ID_W-1:0] id,
                       input logic [CNT_W-1:0] per);
    start    <= 1'b1;
    op       <= o;
    timer_id <= id;
    period   <= per;
    do @(posedge clk); while (busy);
    op_seen[o]++;
    n_issued++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send(input logic [OP_W-1:0] o, input logic [ID_W-1:0] id,
                      input logic [CNT_W-1:0] per);
    int gap;
    issue(o, id, per);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // mostly short periods so timers actually reach the fired state
  function automatic logic [CNT_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 6);
    if (r < 75) return $urandom_range(7, 40);
    if (r < 95) return $urandom;
    case ($urandom_range(0, 2))
      0:       return '1;
      1:       return {{(CNT_W-1){1'b1}}, 1'b0};
      default: return {1'b1, {(CNT_W-1){1'b0}}};
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 28) return OP_TICK;
    if (r < 45) return OP_ALLOC;
    if (r < 65) return OP_SET;
    if (r < 75) return OP_RELEASE;
    if (r < 94) return OP_READ;
    return OP_W'(int'(OP_READ) + $urandom_range(1, 3));
  endfunction

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles", idle_cycles);
        $display("** virtual_timer_bank: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int               r;
    int               n;
    int               next_switch;
    bit               mid_drained;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] per;
    next_switch = 0;
    mid_drained = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed words: reset contents, saturation, fired state, reserved id, unknown ops
    send(OP_READ, 4'd0, '0);
    send(OP_SET, 4'd0, '0);
    send(OP_READ, 4'd0, '0);
    send(OP_SET, 4'd3, '1);
    send(OP_READ, 4'd3, '0);
    send(OP_SET, 4'd7, {{(CNT_W-1){1'b1}}, 1'b0});
    send(OP_SET, 4'd5, 32'd1);
    send(OP_TICK, 4'd9, 32'hFFFF_0000);
    send(OP_READ, 4'd5, '0);
    send(OP_READ, 4'd7, '0);
    send(OP_TICK, '0, '0);
    send(OP_READ, 4'd5, '1);
    send(OP_ALLOC, 4'd15, '1);
    send(OP_ALLOC, '0, '0);
    send(OP_RELEASE, 4'd3, '0);
    send(OP_ALLOC, 4'd3, '0);
    send(OP_W'(int'(OP_READ) + 1), 4'd15, '1);
    send(OP_W'(int'(OP_READ) + 2), 4'd5, 32'h1234_5678);
    send(OP_W'(int'(OP_READ) + 3), 4'd0, '0);
    send(OP_SET, 4'd15, 32'h5A5A_5A5A);
    send(OP_READ, 4'd15, '0);
    send(OP_RELEASE, 4'd0, '1);
    send(OP_READ, 4'd0, '0);
    send(OP_ALLOC, '0, '0);
    drain();

    while (n_issued < 25 + RANDOM_WORDS) begin
      if (n_issued >= next_switch) begin
        gaps_on     = ($urandom_range(0, 3) != 0);
        next_switch = n_issued + $urandom_range(40, 120);
      end
      if (!mid_drained && n_issued >= 25 + RANDOM_WORDS / 2) begin
        drain();
        mid_drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // fill the bank; at least the last allocation finds nothing free
        repeat (ALLOC_LIM) send(OP_ALLOC, ID_W'($urandom), $urandom);
      end else if (r < 22) begin
        // count one timer down to fired, reading it after every tick
        id  = ID_W'($urandom_range(0, NUM_TIMERS - 1));
        per = $urandom_range(0, 4);
        send(OP_SET, id, per);
        for (int j = 0; j <= int'(per) + 1; j++) begin
          send(OP_TICK, ID_W'($urandom), $urandom);
          send(OP_READ, id, $urandom);
        end
      end else if (r < 30) begin
        n = $urandom_range(3, 8);
        repeat (n) send(OP_RELEASE, ID_W'($urandom_range(0, NUM_TIMERS - 1)), $urandom);
      end else begin
        send(pick_op(), ID_W'($urandom_range(0, NUM_TIMERS - 1)), pick_period());
      end
    end

    drain();
    repeat (NUM_TIMERS + 8) @(posedge clk);
    $display("covered %0d words: %0d tick, %0d allocate, %0d set,",
             n_issued, op_seen[OP_TICK], op_seen[OP_ALLOC], op_seen[OP_SET],
             " %0d release, %0d read, %0d other",
             op_seen[OP_RELEASE], op_seen[OP_READ],
             op_seen[5] + op_seen[6] + op_seen[7]);
    $display("reads of fired timers %0d, allocations with the bank full %0d",
             fired_reads, full_allocs);
    if (errors == 0 && pending == 0) begin
      $display("** virtual_timer_bank: PASSED **");
    end else begin
      $display("** virtual_timer_bank: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/vtb_pkg.sv
sv/virtual_timer_bank.sv
tb/virtual_timer_bank_checker.sv
tb/virtual_timer_bank_tb.sv
